>>> hw/rtl/crtd_pkg.sv
// ----------------------------------------------------------------------------
// Comb reverb with tail detection: shared types and constants
// Payload structs, mode and register index codes, and reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package crtd_pkg;

  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_FEEDBACK = 2'd0,
    MODE_ECHO     = 2'd1,
    MODE_LOWPASS  = 2'd2,
    MODE_BYPASS   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_DELAY = 2'd1,
    CFG_GAIN  = 2'd2,
    CFG_LEVEL = 2'd3
  } cfg_idx_e;

  localparam mode_e       MODE_RST  = MODE_FEEDBACK;
  localparam logic [13:0] DELAY_RST = 14'd4410;
  localparam logic [15:0] GAIN_RST  = 16'd16384;
  localparam logic [14:0] LEVEL_RST = 15'd33;
  localparam logic [15:0] GAIN_ONE  = 16'h8000;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               first;
  } crtd_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               tail_end;
  } crtd_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/comb_reverb_with_tail_detect_core.sv
// ----------------------------------------------------------------------------
// Comb reverb with tail detection
// Feedback comb, feedforward echo, lowpass comb or passthrough over a delay
// memory, with a ring of recent output magnitudes that ends the tail.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o   crtd_in_t  (sample_in, first)
//  out      output     out_valid_o / out_stall_i crtd_out_t (sample_out, tail_end)
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
//  A sample is not taken while the one before it is in the multiply stage, set
//  by the delay memory: it is read when a sample is taken and written back when
//  the result commits from the final stage into the output register.
//  Reset clears control state only. Delay entries are read only after they
//  were written in the current buffer, so the memories need no clearing pass.
//  A stalled output holds the pipeline; input is taken again once it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module comb_reverb_with_tail_detect_core
  import crtd_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH  = 16384,
  parameter int unsigned LEVEL_WINDOW = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire crtd_in_t              in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      crtd_out_t             out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned RW = $clog2(LEVEL_WINDOW);
  localparam int unsigned SW = 16 + RW;
  localparam logic [AW-1:0] DLAST   = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]   DDEPTH  = (AW+1)'(DELAY_DEPTH);
  localparam logic [16:0]   DLAST17 = 17'(DELAY_DEPTH - 1);
  localparam logic [RW-1:0] RLAST   = RW'(LEVEL_WINDOW - 1);

  mode_e       mode_q;
  logic [13:0] dly_q;
  logic [15:0] gain_q;
  logic [14:0] lvl_q;

  logic [AW-1:0] wi_q, wi_d;
  logic [14:0]   n_q, n_d;
  logic [RW-1:0] rp_q, rp_d;
  logic          rfull_q, rfull_d;
  logic [SW-1:0] sum_q;
  logic          stopped_q, stopped_d;

  logic [15:0] dly_mem_q [DELAY_DEPTH];
  logic [15:0] ring_mem_q [LEVEL_WINDOW];
  logic [15:0] drd1_q, drd2_q, rrd_q;

  logic                 s1_vld_q, s1_vld_d;
  logic signed [15:0]   s1_x_q;
  logic                 s1_first_q, s1_ge1_q, s1_ge2_q, s1_hit1_q, s1_hit2_q;
  logic [15:0]          s1_fwd_q;
  logic [AW-1:0]        s1_waddr_q;
  logic                 s1_use_q, s1_rvld_q, s1_full_q;
  logic [RW-1:0]        s1_rp_q;

  logic                 s2_vld_q, s2_vld_d;
  logic signed [34:0]   s2_acc_q;
  logic signed [15:0]   s2_x_q;
  logic                 s2_first_q, s2_use_q, s2_rvld_q, s2_full_q;
  logic [AW-1:0]        s2_waddr_q;
  logic [RW-1:0]        s2_rp_q;

  logic      out_vld_q;
  crtd_out_t out_q;

  logic [AW-1:0] m;
  logic [16:0]   dly17;
  logic [15:0]   gain_sat;
  logic [SW-1:0] thresh;

  logic          accept, live_in, kill, s1_go, s2_commit;
  logic [14:0]   n_eff;
  logic [RW-1:0] rp_eff, rp_inc;
  logic          rfull_eff, ge1, ge2, use_in, full_in;
  logic [AW:0]   diff, r1w;
  logic [AW-1:0] r1, r2, wi_inc, wi_dec;
  logic          hit1, hit2;

  logic signed [15:0] d1, d2;
  logic signed [16:0] dsum;
  logic signed [33:0] prod;
  logic signed [34:0] xsh, half, acc;

  logic signed [19:0] yw;
  logic signed [15:0] y;
  logic [15:0]        mag, old, dwd;
  logic [SW-1:0]      base, sum_new;
  logic               ended;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
      dly_q  <= DELAY_RST;
      gain_q <= GAIN_RST;
      lvl_q  <= LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  mode_q <= mode_e'(cfg_wdata_i[1:0]);
        CFG_DELAY: dly_q  <= cfg_wdata_i[13:0];
        CFG_GAIN:  gain_q <= cfg_wdata_i;
        CFG_LEVEL: lvl_q  <= cfg_wdata_i[14:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    dly17 = {3'b000, dly_q};
    if (dly17 > DLAST17) begin
      m = DLAST;
    end else if (dly_q == 14'd0) begin
      m = AW'(1);
    end else begin
      m = dly17[AW-1:0];
    end
    gain_sat = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
    thresh   = SW'(lvl_q) * SW'(LEVEL_WINDOW);
  end

  // Intake: addresses, history flags and pointer updates for the next sample.
  assign s2_commit  = s2_vld_q & (!out_vld_q | !out_stall_i);
  assign in_stall_o = s1_vld_q | (s2_vld_q & !s2_commit);
  assign accept     = in_valid_i & !in_stall_o;
  assign live_in    = accept & !(stopped_q & !in_data_i.first);
  assign kill       = s1_vld_q & stopped_q & !s1_first_q;
  assign s1_go      = s1_vld_q & !kill & (!s2_vld_q | s2_commit);

  always_comb begin
    n_eff     = in_data_i.first ? '0 : n_q;
    rp_eff    = in_data_i.first ? '0 : rp_q;
    rfull_eff = in_data_i.first ? 1'b0 : rfull_q;
    rp_inc    = (rp_eff == RLAST) ? '0 : rp_eff + RW'(1);
    diff      = {1'b0, wi_q} - {1'b0, m};
    r1w       = diff + DDEPTH;
    r1        = diff[AW] ? r1w[AW-1:0] : diff[AW-1:0];
    r2        = (r1 == '0) ? DLAST : r1 - AW'(1);
    wi_inc    = (wi_q == DLAST) ? '0 : wi_q + AW'(1);
    wi_dec    = (wi_q == '0) ? DLAST : wi_q - AW'(1);
    ge1       = {2'b00, n_eff} >= 17'(m);
    ge2       = {2'b00, n_eff} > 17'(m);
    use_in    = (mode_q != MODE_BYPASS) && !((mode_q == MODE_FEEDBACK) && !ge1);
    full_in   = rfull_eff | (rp_eff == RLAST);
    hit1      = s2_commit && (s2_waddr_q == r1);
    hit2      = s2_commit && (s2_waddr_q == r2);
  end

  always_comb begin
    wi_d      = wi_q;
    n_d       = n_q;
    rp_d      = rp_q;
    rfull_d   = rfull_q;
    stopped_d = stopped_q;
    if (live_in) begin
      wi_d    = wi_inc;
      n_d     = (n_eff == 15'h7FFF) ? n_eff : n_eff + 15'd1;
      rp_d    = use_in ? rp_inc : rp_eff;
      rfull_d = use_in ? full_in : rfull_eff;
    end else if (kill) begin
      wi_d    = wi_dec;
    end
    if (accept && in_data_i.first) begin
      stopped_d = 1'b0;
    end else if (s2_commit && ended) begin
      stopped_d = 1'b1;
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (live_in) begin
      s1_vld_d = 1'b1;
    end else if (s1_go || kill) begin
      s1_vld_d = 1'b0;
    end
    s2_vld_d = s2_vld_q;
    if (s1_go) begin
      s2_vld_d = 1'b1;
    end else if (s2_commit) begin
      s2_vld_d = 1'b0;
    end
  end

  // Multiply stage: gain times delayed term (sum of two in lowpass), with input and rounding folded in.
  always_comb begin
    d1 = s1_ge1_q ? signed'(s1_hit1_q ? s1_fwd_q : drd1_q) : 16'sd0;
    d2 = s1_ge2_q ? signed'(s1_hit2_q ? s1_fwd_q : drd2_q) : 16'sd0;
    case (mode_q)
      MODE_LOWPASS: dsum = {d1[15], d1} + {d2[15], d2};
      MODE_BYPASS:  dsum = 17'sd0;
      default:      dsum = {d1[15], d1};
    endcase
    prod = $signed({1'b0, gain_sat}) * dsum;
    if (mode_q == MODE_LOWPASS) begin
      xsh  = {{3{s1_x_q[15]}}, s1_x_q, 16'd0};
      half = 35'sd32768;
    end else begin
      xsh  = {{4{s1_x_q[15]}}, s1_x_q, 15'd0};
      half = 35'sd16384;
    end
    acc = {prod[33], prod} + xsh + half;
  end

  // Final stage: saturate, level ring update and end test.
  always_comb begin
    if (mode_q == MODE_LOWPASS) begin
      yw = {s2_acc_q[34], s2_acc_q[34:16]};
    end else begin
      yw = s2_acc_q[34:15];
    end
    if (!yw[19] && (yw[18:15] != 4'h0)) begin
      y = 16'sh7FFF;
    end else if (yw[19] && (yw[18:15] != 4'hF)) begin
      y = 16'sh8000;
    end else begin
      y = yw[15:0];
    end
    mag     = y[15] ? (~y + 16'd1) : y;
    old     = s2_rvld_q ? rrd_q : '0;
    base    = s2_first_q ? '0 : sum_q;
    sum_new = s2_use_q ? (base - SW'(old) + SW'(mag)) : base;
    ended   = s2_use_q & s2_full_q & (sum_new <= thresh);
    dwd     = ((mode_q == MODE_ECHO) || (mode_q == MODE_BYPASS)) ? s2_x_q : y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      n_q       <= '0;
      rp_q      <= '0;
      rfull_q   <= 1'b0;
      sum_q     <= '0;
      stopped_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      wi_q      <= wi_d;
      n_q       <= n_d;
      rp_q      <= rp_d;
      rfull_q   <= rfull_d;
      stopped_q <= stopped_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      if (s2_commit) begin
        sum_q     <= sum_new;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (live_in) begin
      s1_x_q     <= in_data_i.sample_in;
      s1_first_q <= in_data_i.first;
      s1_ge1_q   <= ge1;
      s1_ge2_q   <= ge2;
      s1_hit1_q  <= hit1;
      s1_hit2_q  <= hit2;
      s1_fwd_q   <= dwd;
      s1_waddr_q <= wi_q;
      s1_use_q   <= use_in;
      s1_rp_q    <= rp_eff;
      s1_rvld_q  <= rfull_eff;
      s1_full_q  <= full_in;
    end
    if (s1_go) begin
      s2_acc_q   <= acc;
      s2_x_q     <= s1_x_q;
      s2_first_q <= s1_first_q;
      s2_waddr_q <= s1_waddr_q;
      s2_use_q   <= s1_use_q;
      s2_rp_q    <= s1_rp_q;
      s2_rvld_q  <= s1_rvld_q;
      s2_full_q  <= s1_full_q;
    end
    if (s2_commit) begin
      out_q.sample_out <= ended ? 16'sd0 : y;
      out_q.tail_end   <= ended;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_commit) begin
      dly_mem_q[s2_waddr_q] <= dwd;
    end
    if (live_in) begin
      drd1_q <= dly_mem_q[r1];
      drd2_q <= dly_mem_q[r2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_commit && s2_use_q) begin
      ring_mem_q[s2_rp_q] <= mag;
    end
    if (live_in) begin
      rrd_q <= ring_mem_q[rp_eff];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  ap_no_intake_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !s1_vld_q)
    else $error("Sample transfer taken while the multiply stage is occupied.");

  ap_commit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_commit |=> out_valid_o)
    else $error("Committed result did not reach the output register.");

  ap_kill_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kill |-> $past(s2_commit && ended))
    else $error("Sample squashed without a preceding end marker.");

  ap_marker_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.tail_end) |-> (out_data_o.sample_out == 16'sd0))
    else $error("End marker carries a nonzero sample.");

  ap_single_stage_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_commit && s1_go) |-> !kill)
    else $error("Squash coincides with a stage advance.");

endmodule

`default_nettype wire

>>> bench/comb_reverb_with_tail_detect_core_tb.sv
// ----------------------------------------------------------------------------
// Comb reverb with tail detection: self-checking testbench
// Drives audio samples through the valid/stall input channel and checks every
// output transfer against values typed in the plan or a bit-accurate predictor
// of the comb, echo, lowpass and passthrough paths and of the level ring that
// ends the tail. A table of directed samples and register writes comes first,
// then buffers of random content under random settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module comb_reverb_with_tail_detect_core_tb;
  import crtd_pkg::*;

  localparam int unsigned DELAY_DEPTH    = 16384;
  localparam int unsigned LEVEL_WINDOW   = 64;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          SAMPLE_TARGET  = 400;
  localparam int          CYCLE_LIMIT    = 1000000;
  localparam int          PLAN_LEN       = 42;

  typedef enum {ROW_CFG, ROW_PRED, ROW_TYPED, ROW_NONE} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    cfg_idx_e           idx;
    logic [15:0]        val;
    logic signed [15:0] smp;
    bit                 first;
    int                 reps;
    logic signed [15:0] out_smp;
    bit                 out_end;
  } step_t;

  typedef struct packed {
    cfg_idx_e    idx;
    logic [15:0] val;
  } reg_write_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  crtd_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  crtd_out_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [1:0]            cfg_idx_i   = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  comb_reverb_with_tail_detect_core #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .LEVEL_WINDOW(LEVEL_WINDOW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  mode_e              eff_mode = MODE_RST;
  longint             dly_len  = longint'(DELAY_RST);
  longint             gain     = longint'(GAIN_RST);
  longint             end_lvl  = longint'(LEVEL_RST);
  logic signed [15:0] dly_mem [DELAY_DEPTH];
  int unsigned        wr_ptr   = 0;
  int unsigned        n_count  = 0;
  longint             lvl_ring [LEVEL_WINDOW];
  int unsigned        lvl_ptr  = 0;
  bit                 lvl_full = 1'b0;
  longint             lvl_sum  = 0;
  bit                 halted   = 1'b0;

  crtd_out_t  due_outputs [$];
  reg_write_t pend_writes [$];

  int  errors            = 0;
  int  samples_sent      = 0;
  int  results_seen      = 0;
  int  tail_ends_seen    = 0;
  int  writes_done       = 0;
  bit  quiet             = 1'b0;
  int  stall_hold        = 0;

  function automatic void clear_level();
    foreach (lvl_ring[i]) lvl_ring[i] = 0;
    lvl_ptr  = 0;
    lvl_full = 1'b0;
    lvl_sum  = 0;
  endfunction

  function automatic bit predict_echo(input crtd_in_t s, output crtd_out_t r);
    longint      x, d1, d2, y, a, m, mag;
    int unsigned wi, n, r1, r2;
    bit          ended;
    x = longint'($signed(s.sample_in));
    r = '0;
    if (s.first) begin
      n_count = 0;
      clear_level();
      halted = 1'b0;
    end
    if (halted) return 1'b0;
    m = dly_len;
    if (m < 1) m = 1;
    if (m > DELAY_DEPTH - 1) m = DELAY_DEPTH - 1;
    a  = (gain > 32768) ? 32768 : gain;
    wi = wr_ptr;
    n  = n_count;
    r1 = (wi + DELAY_DEPTH - int'(m)) % DELAY_DEPTH;
    r2 = (wi + DELAY_DEPTH - int'(m) - 1) % DELAY_DEPTH;
    d1 = 0;
    d2 = 0;
    if (n >= m) d1 = longint'(dly_mem[r1]);
    if (n >= m + 1) d2 = longint'(dly_mem[r2]);
    case (eff_mode)
      MODE_FEEDBACK, MODE_ECHO: y = x + ((a * d1 + (longint'(1) << 14)) >>> 15);
      MODE_LOWPASS: y = x + ((a * (d1 + d2) + (longint'(1) << 15)) >>> 16);
      default: y = x;
    endcase
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    dly_mem[wi] = (eff_mode == MODE_ECHO || eff_mode == MODE_BYPASS) ? x[15:0] : y[15:0];
    wr_ptr = (wi + 1) % DELAY_DEPTH;
    if (n_count < 32767) n_count++;
    ended = 1'b0;
    if (eff_mode != MODE_BYPASS && !(eff_mode == MODE_FEEDBACK && n < m)) begin
      mag = (y < 0) ? -y : y;
      lvl_sum = lvl_sum - lvl_ring[lvl_ptr] + mag;
      lvl_ring[lvl_ptr] = mag;
      lvl_ptr++;
      if (lvl_ptr >= LEVEL_WINDOW) begin
        lvl_ptr  = 0;
        lvl_full = 1'b1;
      end
      ended = lvl_full && (lvl_sum <= end_lvl * LEVEL_WINDOW);
    end
    if (ended) begin
      halted = 1'b1;
      r.sample_out = '0;
      r.tail_end   = 1'b1;
    end else begin
      r.sample_out = y[15:0];
      r.tail_end   = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int sender_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [15:0] loud_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] faint_sample();
    if ($urandom_range(0, 4) != 0) return 16'sd0;
    return 16'($signed($urandom_range(0, 6)) - 3);
  endfunction

  function automatic void queue_write(input cfg_idx_e idx, input logic [15:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    pend_writes.push_back(w);
  endfunction

  task automatic apply_settings();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    foreach (pend_writes[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= pend_writes[i].idx;
      cfg_wdata_i <= pend_writes[i].val;
      @(posedge clk_i);
      writes_done++;
      case (pend_writes[i].idx)
        CFG_MODE:  eff_mode = mode_e'(pend_writes[i].val[1:0]);
        CFG_DELAY: dly_len  = longint'(pend_writes[i].val[13:0]);
        CFG_GAIN:  gain     = longint'(pend_writes[i].val);
        CFG_LEVEL: end_lvl  = longint'(pend_writes[i].val[14:0]);
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    pend_writes.delete();
  endtask

  task automatic push_sample(input logic signed [15:0] smp, input bit first,
                             input row_kind_e kind, input crtd_out_t typed);
    crtd_in_t  d;
    crtd_out_t r;
    bit        made;
    int        g;
    d.sample_in = smp;
    d.first     = first;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    samples_sent++;
    made = predict_echo(d, r);
    if (kind == ROW_TYPED) due_outputs.push_back(typed);
    else if (kind == ROW_PRED && made) due_outputs.push_back(r);
    g = sender_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall_i <= 1'b0;
          stall_hold  <= $urandom_range(0, 6);
        end
        9: begin
          out_stall_i <= 1'b1;
          stall_hold  <= $urandom_range(10, 40);
        end
        default: begin
          out_stall_i <= 1'b1;
          stall_hold  <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : out_check
    crtd_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (out_data_o.tail_end === 1'b1) tail_ends_seen++;
      if (due_outputs.size() == 0) begin
        $error("Output transfer with nothing expected: sample_out %0d, tail_end %0b.",
               out_data_o.sample_out, out_data_o.tail_end);
        errors++;
      end else begin
        want = due_outputs.pop_front();
        if (out_data_o.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d.", want.sample_out,
                 out_data_o.sample_out);
          errors++;
        end
        if (out_data_o.tail_end !== want.tail_end) begin
          $error("tail_end: expected %0b, got %0b.", want.tail_end, out_data_o.tail_end);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  step_t plan [0:PLAN_LEN-1] = '{
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh7FFF, 1'b1, 1,  16'sh7FFF, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh8000, 1'b0, 1,  16'sh8000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_DELAY, 16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_GAIN,  16'hFFFF,  16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sd20000, 1'b1, 1, 16'sd20000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sd20000, 1'b0, 1, 16'sh7FFF, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh8000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_MODE,  16'd1,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_DELAY, 16'd2,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_GAIN,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh8000, 1'b1, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sd12345, 1'b0, 1, 16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh8000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_GAIN,  16'd16384, 16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh8000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_MODE,  16'd2,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_DELAY, 16'd1,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_GAIN,  16'd32768, 16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sd1000, 1'b1, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_MODE,  16'd3,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_LEVEL, 16'd32767, 16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sd12345, 1'b1, 1, 16'sd12345, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'shFFFF, 1'b0, 1,  16'shFFFF, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh0000, 1'b0, 66, 16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_MODE,  16'd1,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_DELAY, 16'd16383, 16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sd7,    1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_DELAY, 16'd1,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_LEVEL, 16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh0000, 1'b1, 1,  16'sh0000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh0000, 1'b0, 62, 16'sh0000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b1},
    '{ROW_NONE,  CFG_MODE,  16'd0,     16'sd5000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_TYPED, CFG_MODE,  16'd0,     16'sd7,    1'b1, 1,  16'sd7,    1'b0},
    '{ROW_CFG,   CFG_MODE,  16'd0,     16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_CFG,   CFG_LEVEL, 16'd32767, 16'sh0000, 1'b0, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh8000, 1'b1, 1,  16'sh0000, 1'b0},
    '{ROW_PRED,  CFG_MODE,  16'd0,     16'sh8000, 1'b0, 70, 16'sh0000, 1'b0}
  };

  initial begin : stimulus
    crtd_out_t   typed;
    logic [15:0] dv, gv, lv;
    int          nbuf, sig_len, tail_len, b, k, r;
    bit          fl;
    foreach (dly_mem[i]) dly_mem[i] = '0;
    clear_level();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int row = 0; row < PLAN_LEN; row++) begin
      if (plan[row].kind == ROW_CFG) begin
        queue_write(plan[row].idx, plan[row].val);
      end else begin
        if (pend_writes.size() != 0) apply_settings();
        typed.sample_out = plan[row].out_smp;
        typed.tail_end   = plan[row].out_end;
        for (r = 0; r < plan[row].reps; r++)
          push_sample(plan[row].smp, plan[row].first && r == 0, plan[row].kind, typed);
      end
    end

    while (samples_sent < SAMPLE_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      queue_write(CFG_MODE, 16'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0: dv = 16'd0;
        1: dv = 16'd16383;
        2: dv = 16'($urandom_range(0, 16383));
        default: dv = 16'($urandom_range(1, 12));
      endcase
      queue_write(CFG_DELAY, dv);
      case ($urandom_range(0, 5))
        0: gv = 16'd0;
        1: gv = GAIN_ONE;
        2: gv = 16'hFFFF;
        3: gv = 16'($urandom);
        default: gv = 16'($urandom_range(16384, 32768));
      endcase
      queue_write(CFG_GAIN, gv);
      case ($urandom_range(0, 4))
        0: lv = 16'd0;
        1: lv = 16'd32767;
        default: lv = 16'($urandom_range(1, 3000));
      endcase
      queue_write(CFG_LEVEL, lv);
      apply_settings();
      nbuf = $urandom_range(1, 3);
      for (b = 0; b < nbuf; b++) begin
        sig_len  = $urandom_range(1, 40);
        tail_len = $urandom_range(0, 90);
        for (k = 0; k < sig_len + tail_len && samples_sent < SAMPLE_TARGET; k++) begin
          fl = (k == 0) && !(b == 0 && $urandom_range(0, 3) == 0);
          if ($urandom_range(0, 29) == 0) fl = 1'b1;
          push_sample((k < sig_len) ? loud_sample() : faint_sample(), fl, ROW_PRED, '0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples under %0d register writes; checked %0d results.",
             samples_sent, writes_done, results_seen);
    $display("Tail end markers seen: %0d, mismatches: %0d.", tail_ends_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
